FILE: src/scp_pkg.sv
// Shared types and constants of the SMTP reply code parser.
`default_nettype none
package scp_pkg;

  localparam int unsigned MaxLineDef = 1024;

  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChDash  = 8'd45;
  localparam logic [7:0] ChZero  = 8'd48;
  localparam logic [7:0] ChNine  = 8'd57;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChCr    = 8'd13;

  localparam logic [15:0] MinCode  = 16'd100;
  localparam logic [15:0] CodeMax  = 16'hFFFF;

  typedef struct packed {
    logic        valid;
    logic [15:0] code;
    logic        failed;
  } res_t;

endpackage
`default_nettype wire

FILE: src/smtp_reply_code_parser.sv
// Top level of the SMTP reply code parser.
// Takes one reply-stream byte per beat and emits one beat per completed
// reply whose code is at least 100 (its code) or per stream end (failure,
// code 0). One byte is taken every cycle while the output is not stalled;
// a byte's result leaves through the input register and the result
// register, with a single parse step between them.
`default_nettype none
module smtp_reply_code_parser #(
  parameter int unsigned MaxLine = scp_pkg::MaxLineDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] stream_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] reply_code
  output logic             m_axis_tuser    // [0] failed
);
  import scp_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  logic       out_free;
  logic       adv;
  logic       s_beat;
  res_t       res;

  assign adv           = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_beat) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tuser;
    end
  end

  scp_line_parser #(
    .MaxLine (MaxLine)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (adv),
    .byte_i (in_byte_q),
    .end_i  (in_end_q),
    .res_o  (res)
  );

  scp_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire

FILE: src/scp_line_parser.sv
// Line scanner and reply tracker: one byte per taken beat.
`default_nettype none
module scp_line_parser #(
  parameter int unsigned MaxLine = scp_pkg::MaxLineDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        take_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic        end_i,
  output scp_pkg::res_t    res_o
);
  import scp_pkg::*;

  localparam int unsigned LenW = $clog2(MaxLine + 1);

  localparam logic [1:0] PhSeek  = 2'd0;
  localparam logic [1:0] PhPass  = 2'd1;
  localparam logic [1:0] PhSpace = 2'd2;
  localparam logic [1:0] PhDone  = 2'd3;

  localparam logic [1:0] PassLast = 2'd3;

  logic            in_cont_q, in_cont_d;
  logic [15:0]     first_q, first_d;
  logic [1:0]      phase_q, phase_d;
  logic            run_q, run_d;
  logic [15:0]     acc_q, acc_d;
  logic [1:0]      skip_q, skip_d;
  logic            mark_q, mark_d;
  logic [LenW-1:0] len_q, len_d;

  logic        is_digit;
  logic        is_space;
  logic [19:0] mul10;
  logic [15:0] acc_next;
  logic [1:0]  skip_inc;
  logic        complete;

  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign is_space = (byte_i == ChSpace) || ((byte_i >= ChTab) && (byte_i <= ChCr));
  assign mul10    = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {16'b0, byte_i[3:0]};
  assign acc_next = (mul10 > {4'b0, CodeMax}) ? CodeMax : mul10[15:0];
  assign skip_inc = skip_q + 2'd1;

  always_comb begin
    in_cont_d = in_cont_q;
    first_d   = first_q;
    phase_d   = phase_q;
    run_d     = run_q;
    acc_d     = acc_q;
    skip_d    = skip_q;
    mark_d    = mark_q;
    len_d     = len_q;
    complete  = 1'b0;
    res_o     = '0;
    if (take_i) begin
      if (end_i) begin
        in_cont_d  = 1'b0;
        first_d    = '0;
        phase_d    = PhSeek;
        run_d      = 1'b0;
        acc_d      = '0;
        skip_d     = '0;
        mark_d     = 1'b0;
        len_d      = '0;
        res_o.valid  = 1'b1;
        res_o.failed = 1'b1;
      end else if (byte_i != ChLf) begin
        if (len_q < LenW'(MaxLine)) begin
          len_d = len_q + LenW'(1);
          if (phase_q == PhSeek) begin
            if (is_digit) begin
              phase_d = PhPass;
              run_d   = 1'b1;
              acc_d   = {12'b0, byte_i[3:0]};
              skip_d  = 2'd1;
            end
          end else begin
            if (run_q) begin
              if (is_digit) begin
                acc_d = acc_next;
              end else begin
                run_d = 1'b0;
              end
            end
            if (phase_q == PhPass) begin
              skip_d = skip_inc;
              if (skip_inc == PassLast) begin
                phase_d = PhSpace;
              end
            end else if (phase_q == PhSpace) begin
              if (!is_space) begin
                if (byte_i == ChDash) begin
                  mark_d = 1'b1;
                end
                phase_d = PhDone;
              end
            end
          end
        end
      end else begin
        phase_d = PhSeek;
        run_d   = 1'b0;
        acc_d   = '0;
        skip_d  = '0;
        mark_d  = 1'b0;
        len_d   = '0;
        if (in_cont_q) begin
          if ((acc_q == first_q) && !mark_q) begin
            in_cont_d = 1'b0;
            complete  = 1'b1;
          end
        end else begin
          first_d   = acc_q;
          in_cont_d = mark_q;
          complete  = !mark_q;
        end
        if (complete && (first_d >= MinCode)) begin
          res_o.valid = 1'b1;
          res_o.code  = first_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cont_q <= 1'b0;
      first_q   <= '0;
      phase_q   <= PhSeek;
      run_q     <= 1'b0;
      acc_q     <= '0;
      skip_q    <= '0;
      mark_q    <= 1'b0;
      len_q     <= '0;
    end else begin
      in_cont_q <= in_cont_d;
      first_q   <= first_d;
      phase_q   <= phase_d;
      run_q     <= run_d;
      acc_q     <= acc_d;
      skip_q    <= skip_d;
      mark_q    <= mark_d;
      len_q     <= len_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.failed |-> res_o.code == '0)
    else $error("failure result carries a nonzero code");
  a_code_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.failed |-> res_o.code >= MinCode)
    else $error("reply code below minimum emitted");
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && end_i |=> !in_cont_q && phase_q == PhSeek && len_q == '0)
    else $error("state not cleared after stream end");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(MaxLine))
    else $error("line length past maximum");
`endif

endmodule
`default_nettype wire

FILE: src/scp_out_stage.sv
// Result register on the master side.
`default_nettype none
module scp_out_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire scp_pkg::res_t res_i,
  output logic               free_o,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [15:0]        m_axis_tdata,
  output logic               m_axis_tuser
);
  import scp_pkg::*;

  logic        valid_q, valid_d;
  logic [15:0] code_q;
  logic        failed_q;
  logic        load;

  assign free_o = !valid_q || m_axis_tready;
  assign load   = adv_i && res_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q   <= res_i.code;
      failed_q <= res_i.failed;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = code_q;
  assign m_axis_tuser  = failed_q;

endmodule
`default_nettype wire

FILE: sim/scp_reply_checker.sv
// Reply checker for the SMTP reply code parser: predicts reply beats and compares them.
module scp_reply_checker #(
  parameter int unsigned MaxLine = scp_pkg::MaxLineDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,
  input  logic        m_tuser_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          replies_o,
  output int          aborts_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import scp_pkg::*;

  typedef enum logic [1:0] {SeekDigit, PassChars, SkipBlanks, LineDone} scan_phase_e;

  typedef struct packed {
    logic [15:0] code;
    logic        failed;
  } reply_t;

  reply_t      expected_replies[$];

  logic        in_multi;
  logic [15:0] first_code;
  scan_phase_e phase;
  logic        in_digits;
  logic [15:0] line_code;
  logic [1:0]  passed;
  logic        line_cont;
  logic [10:0] line_len;

  function automatic logic is_digit(logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  task automatic clear_line();
    phase     = SeekDigit;
    in_digits = 1'b0;
    line_code = '0;
    passed    = '0;
    line_cont = 1'b0;
    line_len  = '0;
  endtask

  task automatic reset_parser();
    in_multi   = 1'b0;
    first_code = '0;
    clear_line();
  endtask

  task automatic scan_char(input logic [7:0] c);
    int unsigned acc;
    if (phase == SeekDigit) begin
      if (is_digit(c)) begin
        phase     = PassChars;
        in_digits = 1'b1;
        line_code = 16'(c - ChZero);
        passed    = 2'd1;
      end
      return;
    end
    if (in_digits) begin
      if (is_digit(c)) begin
        acc       = 32'(line_code) * 10 + 32'(c - ChZero);
        line_code = (acc > 32'(CodeMax)) ? CodeMax : acc[15:0];
      end else begin
        in_digits = 1'b0;
      end
    end
    if (phase == PassChars) begin
      passed = passed + 2'd1;
      if (passed == 2'd3) phase = SkipBlanks;
    end else if (phase == SkipBlanks) begin
      if (!is_blank(c)) begin
        if (c == ChDash) line_cont = 1'b1;
        phase = LineDone;
      end
    end
  endtask

  task automatic predict_reply(input logic [7:0] c, input logic stream_end);
    logic [15:0] code;
    logic        cont;
    logic        complete;
    complete = 1'b0;
    if (stream_end) begin
      reset_parser();
      expected_replies.push_back('{code: 16'd0, failed: 1'b1});
      return;
    end
    if (c != ChLf) begin
      if (line_len < 11'(MaxLine)) begin
        line_len = line_len + 11'd1;
        scan_char(c);
      end
      return;
    end
    code = line_code;
    cont = line_cont;
    clear_line();
    if (in_multi) begin
      if (code == first_code && !cont) begin
        in_multi = 1'b0;
        complete = 1'b1;
      end
    end else begin
      first_code = code;
      in_multi   = cont;
      complete   = !cont;
    end
    if (complete && first_code >= MinCode)
      expected_replies.push_back('{code: first_code, failed: 1'b0});
  endtask

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("%t %s", $realtime, msg);
  endtask

  task automatic check_reply(input logic [15:0] code, input logic failed);
    reply_t exp_reply;
    if (expected_replies.size() == 0) begin
      report_mismatch($sformatf("unexpected beat: code %0d failed %b", code, failed));
      return;
    end
    exp_reply = expected_replies.pop_front();
    if (exp_reply.failed) aborts_o++;
    else replies_o++;
    if (code !== exp_reply.code || failed !== exp_reply.failed)
      report_mismatch($sformatf(
        "reply mismatch: expected code %0d failed %b, got code %0d failed %b",
        exp_reply.code, exp_reply.failed, code, failed));
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    replies_o    = 0;
    aborts_o     = 0;
    reset_parser();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_parser();
      expected_replies.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) check_reply(m_tdata_i, m_tuser_i);
      if (s_tvalid_i && s_tready_i) predict_reply(s_tdata_i, s_tuser_i);
    end
    pending_o = expected_replies.size();
  end

endmodule

FILE: sim/tb_smtp_reply_code_parser.sv
// Testbench top for the SMTP reply code parser: drives reply streams and gives the verdict.
module tb_smtp_reply_code_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import scp_pkg::*;

  localparam int CycleLimit = 500000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        s_axis_tuser;   // [0] stream_end
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [15:0] reply_code
  logic        m_axis_tuser;   // [0] failed

  int fail_count;
  int pending;
  int replies;
  int aborts;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int bytes_sent;
  int lines_sent;

  smtp_reply_code_parser i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  scp_reply_checker i_checker (
    .clk_i,
    .rst_ni,
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .replies_o   (replies),
    .aborts_o    (aborts)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic stream_end);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= stream_end;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    if (!stream_end && b == ChLf) lines_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  function automatic logic [7:0] blank_char();
    return ($urandom_range(1) == 0) ? ChSpace : 8'(ChTab + $urandom_range(4));
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    return (b == ChLf) ? 8'hFF : b;
  endfunction

  function automatic int unsigned pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(100, 599);
    if (r < 88) return $urandom_range(0, 99);
    return $urandom_range(1000, 999999);
  endfunction

  task automatic send_noise_line();
    repeat ($urandom_range(0, 12)) send_beat(noise_char(), 1'b0);
    send_beat(ChLf, 1'b0);
  endtask

  task automatic send_reply_line(input int unsigned code, input logic mark_cont);
    string digits;
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(65, 90)), 1'b0);
    digits = $sformatf("%0d", code);
    if ($urandom_range(9) == 0) digits = {"0", digits};
    send_text(digits);
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) send_beat(blank_char(), 1'b0);
    if (mark_cont) send_beat(ChDash, 1'b0);
    else if ($urandom_range(1)) send_beat(ChSpace, 1'b0);
    repeat ($urandom_range(0, 10)) send_beat(8'($urandom_range(33, 126)), 1'b0);
    if ($urandom_range(1)) send_beat(ChCr, 1'b0);
    send_beat(ChLf, 1'b0);
  endtask

  task automatic send_random_reply();
    int unsigned code;
    int r;
    code = pick_code();
    if ($urandom_range(99) < 40) begin
      send_reply_line(code, 1'b1);
      repeat ($urandom_range(0, 3)) begin
        r = $urandom_range(99);
        if (r < 50) send_reply_line(code, 1'b1);
        else if (r < 80) send_reply_line(pick_code(), 1'($urandom_range(1)));
        else send_noise_line();
      end
      if ($urandom_range(9) != 0) send_reply_line(code, 1'b0);
    end else begin
      send_reply_line(code, 1'b0);
    end
  endtask

  task automatic send_long_line();
    logic [7:0] b;
    repeat (MaxLineDef) begin
      b = noise_char();
      if (b >= ChZero && b <= ChNine) b = ChSpace;
      send_beat(b, 1'b0);
    end
    send_text("354 \n");
  endtask

  task automatic run_random(input int target);
    int r;
    while (bytes_sent < target) begin
      r = $urandom_range(99);
      if (r < 6) send_beat(8'($urandom_range(255)), 1'b1);
      else if (r < 18) send_noise_line();
      else send_random_reply();
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cycle_count   = 0;
    bytes_sent    = 0;
    lines_sent    = 0;
    send_idle_pct = 16;
    recv_idle_pct = 72;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    send_beat(8'($urandom_range(255)), 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(ChLf, 1'b0);
    send_text("12\n");
    send_text("250\t\015-x\n");
    send_text("250\n");
    send_text("99999\n");
    send_beat(8'h34, 1'b0);
    send_beat(8'h00, 1'b1);

    run_random(300);
    send_idle_pct = 72;
    recv_idle_pct = 16;
    run_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_long_line();
    run_random(1720);
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Sent %0d bytes in %0d lines, including one over-length line.", bytes_sent,
             lines_sent);
    $display("Checked %0d reply codes and %0d stream-end failures.", replies, aborts);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
src/scp_pkg.sv
src/scp_line_parser.sv
src/scp_out_stage.sv
src/smtp_reply_code_parser.sv
sim/scp_reply_checker.sv
sim/tb_smtp_reply_code_parser.sv
